FILE: rtl/pdcb_pkg.sv
// ----------------------------------------------------------------------------
// pdcb_pkg
// Shared widths, payload types, queue job type and register codes for the
// speaker pin to audio sample block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdcb_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int CNT_W       = 26;
	localparam int ACC_W       = CNT_W + 1;
	localparam int RATE_W      = 18;
	localparam int COEF_W      = 16;
	localparam int AUDIO_W     = FRAC_BITS + 2;
	localparam int DUTY_W      = FRAC_BITS + 1;
	localparam int MAG_W       = FRAC_BITS + 1;
	localparam int PROD_W      = MAG_W + COEF_W;
	localparam int SUM_W       = FRAC_BITS + 4;
	localparam int DIV_CNT_W   = $clog2(DUTY_W);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [1:0] REG_CORE_FREQUENCY   = 2'd0;
	localparam logic [1:0] REG_OUT_RATE         = 2'd1;
	localparam logic [1:0] REG_POLE_COEFFICIENT = 2'd2;
	localparam logic [1:0] REG_ENABLE           = 2'd3;

	localparam logic [CNT_W-1:0]  RST_CORE_FREQUENCY   = CNT_W'(16000000);
	localparam logic [RATE_W-1:0] RST_OUT_RATE         = RATE_W'(44100);
	localparam logic [COEF_W-1:0] RST_POLE_COEFFICIENT = COEF_W'(65470);

	typedef struct packed {
		logic speaker_level;
		logic halt;
	} tick_t;

	typedef struct packed {
		logic signed [AUDIO_W-1:0] audio_sample;
		logic [DUTY_W-1:0]         duty;
	} sample_t;

	typedef struct packed {
		logic [CNT_W-1:0]  core_frequency;
		logic [RATE_W-1:0] out_rate;
		logic              enable;
	} front_cfg_t;

	typedef struct packed {
		logic             zero;
		logic             clear;
		logic [CNT_W-1:0] high;
		logic [CNT_W-1:0] span;
	} job_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_WRITE
	} back_state_t;

endpackage

`default_nettype wire

FILE: rtl/pwm_pin_to_audio_dc_block.sv
// ----------------------------------------------------------------------------
// pwm_pin_to_audio_dc_block
// Speaker pin level to PCM: per-slice duty in Q1.16 followed by a one-pole
// DC-blocking high pass, saturated to plus or minus one.
//
//   channel  direction  handshake                     payload
//   tick     in         tick_valid / tick_stall       tick_t   (level, halt)
//   sample   out        sample_valid / sample_stall   sample_t (audio, duty)
//   config   in         APB psel/penable/pwrite       32-bit registers
//
// One tick item is accepted per cycle while the job queue has room.
// In the back end the duty divider resolves one quotient bit per cycle;
// zero samples skip the divider and go straight to the write state.
// The four-entry job queue absorbs bursts of slice ends; tick_stall rises
// only when it is full, and sample_stall holds the output register.
// Reset brings all counters, filter state and the halt flag to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_pin_to_audio_dc_block (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [pdcb_pkg::ADDR_W-1:0]   paddr,
	input  wire [pdcb_pkg::DATA_W-1:0]   pwdata,
	output logic [pdcb_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  wire                          tick_valid,
	output logic                         tick_stall,
	input  pdcb_pkg::tick_t              tick,
	output logic                         sample_valid,
	input  wire                          sample_stall,
	output pdcb_pkg::sample_t            sample
);
	import pdcb_pkg::*;

	logic [CNT_W-1:0]  core_frequency_q;
	logic [RATE_W-1:0] out_rate_q;
	logic [COEF_W-1:0] pole_coefficient_q;
	logic              enable_q;

	logic       cfg_write;
	logic [1:0] reg_index;
	front_cfg_t front_cfg;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	job_t       push_job;
	job_t       pop_job;

	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_frequency_q   <= RST_CORE_FREQUENCY;
			out_rate_q         <= RST_OUT_RATE;
			pole_coefficient_q <= RST_POLE_COEFFICIENT;
			enable_q           <= 1'b1;
		end else if (cfg_write) begin
			case (reg_index)
				REG_CORE_FREQUENCY:   core_frequency_q   <= pwdata[CNT_W-1:0];
				REG_OUT_RATE:         out_rate_q         <= pwdata[RATE_W-1:0];
				REG_POLE_COEFFICIENT: pole_coefficient_q <= pwdata[COEF_W-1:0];
				REG_ENABLE:           enable_q           <= pwdata[0];
				default:              enable_q           <= enable_q;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_CORE_FREQUENCY:   prdata = DATA_W'(core_frequency_q);
			REG_OUT_RATE:         prdata = DATA_W'(out_rate_q);
			REG_POLE_COEFFICIENT: prdata = DATA_W'(pole_coefficient_q);
			REG_ENABLE:           prdata = DATA_W'(enable_q);
			default:              prdata = '0;
		endcase
	end

	assign front_cfg.core_frequency = core_frequency_q;
	assign front_cfg.out_rate       = out_rate_q;
	assign front_cfg.enable         = enable_q;

	pdcb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (front_cfg),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.push       (q_push),
		.push_job   (push_job),
		.full       (q_full)
	);

	pdcb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	pdcb_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pole_coefficient (pole_coefficient_q),
		.empty            (q_empty),
		.pop_job          (pop_job),
		.pop              (q_pop),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.sample           (sample)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job popped from empty queue");

	a_audio_range: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> (sample.audio_sample <= AUDIO_W'(1 << FRAC_BITS))
			&& (sample.audio_sample >= -AUDIO_W'(1 << FRAC_BITS)))
		else $error("audio sample outside saturation range");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> sample.duty <= DUTY_W'(1 << FRAC_BITS))
		else $error("duty above one");

endmodule

`default_nettype wire

FILE: rtl/pdcb_front.sv
// ----------------------------------------------------------------------------
// pdcb_front
// Tick front end: phase accumulator, slice counters and halt tracking.
// Emits one job to the queue at every slice end and at a halt tick while running.
// ----------------------------------------------------------------------------
`default_nettype none

module pdcb_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pdcb_pkg::front_cfg_t cfg,
	input  wire                 tick_valid,
	output logic                tick_stall,
	input  pdcb_pkg::tick_t     tick,
	output logic                push,
	output pdcb_pkg::job_t      push_job,
	input  wire                 full
);
	import pdcb_pkg::*;

	logic [CNT_W-1:0] acc_q;
	logic [CNT_W-1:0] high_q;
	logic [CNT_W-1:0] slice_q;
	logic             halted_q;
	logic             clr_pend_q;

	logic             accept;
	logic [ACC_W-1:0] acc_sum;
	logic [ACC_W-1:0] acc_diff;
	logic             boundary;
	logic             wrap_clear;
	logic [CNT_W-1:0] acc_next;
	logic [CNT_W-1:0] high_inc;
	logic [CNT_W-1:0] slice_inc;

	assign tick_stall = full;
	assign accept     = tick_valid && !full;

	assign acc_sum    = {1'b0, acc_q} + {{(ACC_W-RATE_W){1'b0}}, cfg.out_rate};
	assign boundary   = acc_sum >= {1'b0, cfg.core_frequency};
	assign acc_diff   = acc_sum - {1'b0, cfg.core_frequency};
	assign wrap_clear = acc_diff >= {1'b0, cfg.core_frequency};

	always_comb begin
		if (!boundary) begin
			acc_next = acc_sum[CNT_W-1:0];
		end else if (wrap_clear) begin
			acc_next = '0;
		end else begin
			acc_next = acc_diff[CNT_W-1:0];
		end
	end

	assign slice_inc = (&slice_q) ? slice_q : slice_q + CNT_W'(1);
	assign high_inc  = (tick.speaker_level && !(&high_q)) ? high_q + CNT_W'(1) : high_q;

	always_comb begin
		push           = 1'b0;
		push_job.zero  = 1'b1;
		push_job.clear = clr_pend_q;
		push_job.high  = high_inc;
		push_job.span  = slice_inc;
		if (accept) begin
			if (!cfg.enable) begin
				push           = boundary;
				push_job.clear = 1'b1;
			end else if (halted_q) begin
				push = boundary;
			end else begin
				push          = boundary || tick.halt;
				push_job.zero = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			high_q     <= '0;
			slice_q    <= '0;
			halted_q   <= 1'b0;
			clr_pend_q <= 1'b0;
		end else if (accept) begin
			acc_q <= acc_next;
			if (!cfg.enable) begin
				high_q     <= '0;
				slice_q    <= '0;
				clr_pend_q <= !boundary;
			end else if (halted_q) begin
				if (boundary) begin
					clr_pend_q <= 1'b0;
				end
			end else if (boundary || tick.halt) begin
				high_q     <= '0;
				slice_q    <= '0;
				clr_pend_q <= 1'b0;
				halted_q   <= tick.halt;
			end else begin
				high_q  <= high_inc;
				slice_q <= slice_inc;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pdcb_queue.sv
// ----------------------------------------------------------------------------
// pdcb_queue
// Short job queue between the tick front end and the sample back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pdcb_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  pdcb_pkg::job_t push_job,
	output logic           full,
	input  wire            pop,
	output pdcb_pkg::job_t pop_job,
	output logic           empty
);
	import pdcb_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pdcb_back.sv
// ----------------------------------------------------------------------------
// pdcb_back
// Sample back end: bit-serial duty divider, DC-blocking high pass filter
// with saturation, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdcb_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire [pdcb_pkg::COEF_W-1:0] pole_coefficient,
	input  wire                      empty,
	input  pdcb_pkg::job_t           pop_job,
	output logic                     pop,
	output logic                     sample_valid,
	input  wire                      sample_stall,
	output pdcb_pkg::sample_t        sample
);
	import pdcb_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_ONE    = SUM_W'(1 << FRAC_BITS);
	localparam logic [PROD_W:0]         ROUND_HALF = (PROD_W+1)'(1 << (COEF_W-1));

	back_state_t state_q;
	back_state_t state_d;

	logic [DIV_CNT_W-1:0]      cnt_q;
	logic [ACC_W-1:0]          rem_q;
	logic [CNT_W-1:0]          span_q;
	logic [DUTY_W-1:0]         quo_q;
	logic [PROD_W-1:0]         prod_q;
	logic                      zero_q;
	logic [DUTY_W-1:0]         prev_duty_q;
	logic signed [AUDIO_W-1:0] prev_out_q;
	logic                      sample_valid_q;
	sample_t                   sample_q;

	logic                      out_free;
	logic                      load;
	logic                      step;
	logic                      write;
	logic                      div_bit;
	logic [ACC_W-1:0]          rem_sub;
	logic                      neg;
	logic [AUDIO_W-1:0]        mag_full;
	logic [MAG_W-1:0]          mag;
	logic [PROD_W-1:0]         prod_next;
	logic [PROD_W:0]           prod_rnd;
	logic [MAG_W-1:0]          fb_mag;
	logic signed [SUM_W-1:0]   fb_ext;
	logic signed [SUM_W-1:0]   fb_s;
	logic signed [SUM_W-1:0]   hp;
	logic signed [SUM_W-1:0]   hp_sat;

	assign sample_valid = sample_valid_q;
	assign sample       = sample_q;
	assign out_free     = !sample_valid_q || !sample_stall;

	assign div_bit = rem_q >= {1'b0, span_q};
	assign rem_sub = div_bit ? rem_q - {1'b0, span_q} : rem_q;

	assign neg       = prev_out_q[AUDIO_W-1];
	assign mag_full  = neg ? AUDIO_W'(0) - prev_out_q : prev_out_q;
	assign mag       = mag_full[MAG_W-1:0];
	assign prod_next = PROD_W'(mag) * PROD_W'(pole_coefficient);

	assign prod_rnd = {1'b0, prod_q} + ROUND_HALF;
	assign fb_mag   = prod_rnd[COEF_W +: MAG_W];
	assign fb_ext   = {{(SUM_W-MAG_W){1'b0}}, fb_mag};
	assign fb_s     = neg ? SUM_W'(0) - fb_ext : fb_ext;
	assign hp       = {{(SUM_W-DUTY_W){1'b0}}, quo_q}
	                - {{(SUM_W-DUTY_W){1'b0}}, prev_duty_q} + fb_s;

	always_comb begin
		if (hp > SUM_ONE) begin
			hp_sat = SUM_ONE;
		end else if (hp < -SUM_ONE) begin
			hp_sat = -SUM_ONE;
		end else begin
			hp_sat = hp;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		step    = 1'b0;
		write   = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					load    = 1'b1;
					state_d = pop_job.zero ? B_WRITE : B_DIV;
				end
			end
			B_DIV: begin
				step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DUTY_W-1)) begin
					state_d = B_WRITE;
				end
			end
			B_WRITE: begin
				if (out_free) begin
					write   = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			cnt_q          <= '0;
			prev_duty_q    <= '0;
			prev_out_q     <= '0;
			sample_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				cnt_q <= '0;
				if (pop_job.clear) begin
					prev_duty_q <= '0;
					prev_out_q  <= '0;
				end
			end else if (step) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			if (write) begin
				sample_valid_q <= 1'b1;
				if (!zero_q) begin
					prev_duty_q <= quo_q;
					prev_out_q  <= hp_sat[AUDIO_W-1:0];
				end
			end else if (!sample_stall) begin
				sample_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			zero_q <= pop_job.zero;
			rem_q  <= {1'b0, pop_job.high};
			span_q <= pop_job.span;
		end else if (step) begin
			rem_q  <= {rem_sub[CNT_W-1:0], 1'b0};
			quo_q  <= {quo_q[DUTY_W-2:0], div_bit};
			prod_q <= prod_next;
		end
		if (write) begin
			if (zero_q) begin
				sample_q.audio_sample <= '0;
				sample_q.duty         <= '0;
			end else begin
				sample_q.audio_sample <= hp_sat[AUDIO_W-1:0];
				sample_q.duty         <= quo_q;
			end
		end
	end

endmodule

`default_nettype wire
